// ===== hdl/bfh_pkg.sv =====
// Shared constants and types for the byte frequency histogram.
`timescale 1ns / 1ps
package bfh_pkg;

  localparam int NUM_BINS      = 256;
  localparam int BIN_W         = 8;
  localparam int TEXT_FIRST    = 33;   // one past space
  localparam int TEXT_LAST     = 90;   // 'Z'
  localparam int TEXT_LEN      = TEXT_LAST - TEXT_FIRST + 1;
  localparam int REPORT_W      = 32;
  localparam int COUNT_W_DEF   = 32;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int OQ_DEPTH      = 3;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [PADDR_W-3:0] REG_TEXT_MODE = '0;

  localparam logic [BIN_W-1:0] LOWER_A = 8'h61;
  localparam logic [BIN_W-1:0] LOWER_Z = 8'h7a;
  localparam logic [BIN_W-1:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic                vld;
    logic [BIN_W-1:0]    bin;
    logic [REPORT_W-1:0] count;
    logic                last_bin;
  } res_t;

endpackage

// ===== hdl/byte_frequency_histogram_top.sv =====
// Top level of the byte frequency histogram: config port, bin select, counters, output queue.
// Throughput: one word per cycle, count and read words alike, with out_ready_i held high.
// Read path: the memory read is registered at a read word's accept edge, then the updated
//   result is written into the output queue, from which out_valid_o and the result come.
//   Count words give no result.
// Rate is set by the read-modify-write of the bin memory (one read and one write port),
//   forwarded so back-to-back hits on one bin need no bubble.
// Reset: valid bits clear every bin at once (no sweep), pointer and text_mode go to 0.
`timescale 1ns / 1ps
module byte_frequency_histogram_top #(
  parameter int COUNT_WIDTH = bfh_pkg::COUNT_W_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfh_pkg::PADDR_W-1:0]  paddr,
  input  logic [bfh_pkg::PDATA_W-1:0]  pwdata,
  output logic [bfh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [bfh_pkg::BIN_W-1:0]    data_byte_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bfh_pkg::BIN_W-1:0]    bin_o,
  output logic [bfh_pkg::REPORT_W-1:0] count_o,
  output logic                         last_bin_o
);

  logic                      text_mode_q, text_mode_d;
  logic                      cfg_wr;
  logic                      accept;
  logic [bfh_pkg::BIN_W-1:0] addr;
  logic                      last;
  logic                      s1_read;
  bfh_pkg::res_t             res;

  // register select is paddr[2]; low bits are byte lanes and ignored
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    text_mode_d = text_mode_q;
    if (cfg_wr && (paddr[bfh_pkg::PADDR_W-1:2] == bfh_pkg::REG_TEXT_MODE)) begin
      text_mode_d = pwdata[0];
    end
    prdata = '0;
    if (paddr[bfh_pkg::PADDR_W-1:2] == bfh_pkg::REG_TEXT_MODE) begin
      prdata[0] = text_mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b0;
    end else begin
      text_mode_q <= text_mode_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // bin address: folded data byte, or next bin of the report range
  bfh_idx u_idx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_mode_i (text_mode_q),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .addr_o      (addr),
    .last_o      (last)
  );

  // counter memory: increment-saturate on count words, read-and-clear on read words
  bfh_bins #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .addr_i    (addr),
    .last_i    (last),
    .s1_read_o (s1_read),
    .res_o     (res)
  );

  // output queue; input ready comes from its registered fill level and the read in stage 1
  bfh_oq u_oq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .s1_read_i   (s1_read),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_o       (bin_o),
    .count_o     (count_o),
    .last_bin_o  (last_bin_o)
  );

endmodule

// ===== hdl/bfh_idx.sv =====
// Bin select: case folding for count words, report pointer for read words.
`timescale 1ns / 1ps
module bfh_idx (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    text_mode_i,
  input  logic                    accept_i,
  input  logic                    cmd_i,
  input  logic [bfh_pkg::BIN_W-1:0] data_byte_i,
  output logic [bfh_pkg::BIN_W-1:0] addr_o,
  output logic                    last_o
);

  logic [bfh_pkg::BIN_W-1:0] rd_off_q, rd_off_d;
  logic [bfh_pkg::BIN_W-1:0] off;
  logic [bfh_pkg::BIN_W-1:0] base;
  logic [bfh_pkg::BIN_W-1:0] last_off;
  logic [bfh_pkg::BIN_W-1:0] fold_byte;
  logic                      is_lower;

  always_comb begin
    is_lower  = (data_byte_i >= bfh_pkg::LOWER_A) && (data_byte_i <= bfh_pkg::LOWER_Z);
    fold_byte = (text_mode_i && is_lower) ? data_byte_i - bfh_pkg::CASE_OFFSET
                                          : data_byte_i;
    base     = text_mode_i ? bfh_pkg::BIN_W'(bfh_pkg::TEXT_FIRST) : '0;
    last_off = text_mode_i ? bfh_pkg::BIN_W'(bfh_pkg::TEXT_LEN - 1)
                           : bfh_pkg::BIN_W'(bfh_pkg::NUM_BINS - 1);
    // an out-of-range offset after a mode switch restarts the range
    off      = (rd_off_q > last_off) ? '0 : rd_off_q;
    last_o   = (off == last_off);
    addr_o   = (cmd_i == bfh_pkg::CMD_READ) ? base + off : fold_byte;
    rd_off_d = rd_off_q;
    if (accept_i && (cmd_i == bfh_pkg::CMD_READ)) begin
      rd_off_d = last_o ? '0 : off + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_off_q <= '0;
    end else begin
      rd_off_q <= rd_off_d;
    end
  end

endmodule

// ===== hdl/bfh_bins.sv =====
// Bin counter memory with read-modify-write and write forwarding.
`timescale 1ns / 1ps
module bfh_bins #(
  parameter int COUNT_WIDTH = bfh_pkg::COUNT_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      cmd_i,
  input  logic [bfh_pkg::BIN_W-1:0] addr_i,
  input  logic                      last_i,
  output logic                      s1_read_o,
  output bfh_pkg::res_t             res_o
);

  logic [COUNT_WIDTH-1:0]    mem [bfh_pkg::NUM_BINS];
  logic [bfh_pkg::NUM_BINS-1:0] valid_q;

  logic [COUNT_WIDTH-1:0]    rd_data_q;
  logic                      rd_vld_q;
  logic                      s1_vld_q;
  logic                      s1_cmd_q;
  logic [bfh_pkg::BIN_W-1:0] s1_addr_q;
  logic                      s1_last_q;

  logic                      fwd_vld_q;
  logic [bfh_pkg::BIN_W-1:0] fwd_addr_q;
  logic [COUNT_WIDTH-1:0]    fwd_data_q;

  logic [COUNT_WIDTH-1:0]    cur;
  logic [COUNT_WIDTH-1:0]    nxt;
  logic [bfh_pkg::REPORT_W-1:0] rep;

  // stage 0: read memory and valid bit; also the stage 1 write-back and forwarding registers
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[addr_i];
    s1_cmd_q  <= cmd_i;
    s1_addr_q <= addr_i;
    s1_last_q <= last_i;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= nxt;
    if (s1_vld_q) begin
      mem[s1_addr_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= valid_q[addr_i];
      s1_vld_q  <= accept_i;
      fwd_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // stage 1: update; the last write is not yet in rd_data_q, so it is forwarded
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == s1_addr_q)) begin
      cur = fwd_data_q;
    end else begin
      cur = rd_vld_q ? rd_data_q : '0;
    end
    if (s1_cmd_q == bfh_pkg::CMD_READ) begin
      nxt = '0;
    end else begin
      nxt = (&cur) ? cur : cur + 1'b1;
    end
  end

  if (COUNT_WIDTH > bfh_pkg::REPORT_W) begin : g_clip
    assign rep = (|cur[COUNT_WIDTH-1:bfh_pkg::REPORT_W]) ? '1 : cur[bfh_pkg::REPORT_W-1:0];
  end else begin : g_ext
    assign rep = bfh_pkg::REPORT_W'(cur);
  end

  assign s1_read_o = s1_vld_q && (s1_cmd_q == bfh_pkg::CMD_READ);

  always_comb begin
    res_o.vld      = s1_read_o;
    res_o.bin      = s1_addr_q;
    res_o.count    = rep;
    res_o.last_bin = s1_last_q;
  end

endmodule

// ===== hdl/bfh_oq.sv =====
// Small output queue decoupling the result side from the update stage.
`timescale 1ns / 1ps
module bfh_oq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfh_pkg::res_t                res_i,
  input  logic                         s1_read_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bfh_pkg::BIN_W-1:0]    bin_o,
  output logic [bfh_pkg::REPORT_W-1:0] count_o,
  output logic                         last_bin_o
);

  localparam int PTR_W = $clog2(bfh_pkg::OQ_DEPTH);
  localparam int CNT_W = $clog2(bfh_pkg::OQ_DEPTH + 1);

  bfh_pkg::res_t    buf_q [bfh_pkg::OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;
  logic [CNT_W:0]   pending;

  always_comb begin
    push     = res_i.vld;
    pop      = out_valid_o && out_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(bfh_pkg::OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(bfh_pkg::OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
    // reserve room for the result still in flight
    pending    = {1'b0, cnt_q} + (CNT_W + 1)'(s1_read_i);
    in_ready_o = pending < (CNT_W + 1)'(bfh_pkg::OQ_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign bin_o       = buf_q[rd_ptr_q].bin;
  assign count_o     = buf_q[rd_ptr_q].count;
  assign last_bin_o  = buf_q[rd_ptr_q].last_bin;

endmodule
